// ----- src/asl_pkg.sv -----
// Shared types, operation codes and priority constants of the aging slot table.
package asl_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int ADDR_W = 16;
    localparam int PRIO_W = 6;

    localparam logic [PRIO_W-1:0] PRIO_MAX = 6'd40;
    localparam logic [PRIO_W-1:0] PRIO_NEW = 6'd20;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_AGE    = 2'd1;
    localparam logic [1:0] OP_MARK   = 2'd2;

    // Contents of one slot as it travels along the ring.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PRIO_W-1:0] prio;
        logic              used;
    } t_slot;

    // Update applied by a cell to the slot it hands to its neighbor.
    typedef struct packed {
        logic              age;
        logic              mark;
        logic              write;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

endpackage

// ----- src/asl_if.sv -----
// Request and response channel interfaces of the aging slot table.
interface asl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [3:0]  mark_index;

    modport source (output valid, output operation, output address, output mark_index,
                    input ready);
    modport sink   (input valid, input operation, input address, input mark_index,
                    output ready);
endinterface

interface asl_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot_index;
    logic       was_found;

    modport source (output valid, output slot_index, output was_found, input ready);
    modport sink   (input valid, input slot_index, input was_found, output ready);
endinterface

// ----- src/asl_cell.sv -----
// One slot cell of the ring: holds a slot and hands its updated copy onward.
module asl_cell
    import asl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_cmd  i_cmd,
    input  t_slot i_prev,
    output t_slot o_next
);

    t_slot r_slot;
    t_slot n_slot;

    // The slot as it leaves this cell, with the requested update applied.
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.age) begin
            if (r_slot.used) begin
                n_slot.used = 1'b0;
                if (r_slot.prio < PRIO_MAX) begin
                    n_slot.prio = r_slot.prio + 1'b1;
                end
            end else if (r_slot.prio != '0) begin
                n_slot.prio = r_slot.prio - 1'b1;
            end
        end
        if (i_cmd.mark) begin
            n_slot.used = 1'b1;
        end
        if (i_cmd.write) begin
            n_slot.addr = i_cmd.addr;
            n_slot.prio = PRIO_NEW;
        end
    end

    assign o_next = n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_prev;
        end
    end

endmodule

// ----- src/aging_slot_table.sv -----
// Top level of the aging slot table: a rotating ring of slot cells and its scan control.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------
//  i_req    | in  | valid / ready | operation, address, mark_index
//  o_rsp    | out | valid / ready | slot_index, was_found
//
// One request is worked on at a time. The slots sit in a ring of SLOTS cells
// that rotates by one cell per cycle during a pass, and one pass brings every
// slot past the head cell once. An aging tick or a mark takes one pass, a
// lookup that hits takes one pass, and a lookup that misses takes two (search,
// then write of the chosen slot). After the last pass the result state loads
// the result into the output register; an unused operation code goes there
// straight from idle, with no pass. The block then returns to idle, where the
// next request is taken. Reset is synchronous and clears every slot to address
// 0, priority 0, flag clear. A stalled response only holds the block while the
// next result is ready to be loaded; a new request is accepted while the
// previous result still waits to be taken.
module aging_slot_table
    import asl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    asl_req_if.sink      i_req,
    asl_rsp_if.source    o_rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW = 9;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FIND   = 5'b00010,
        S_WRITE  = 5'b00100,
        S_UPDATE = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Request held for the whole scan.
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_key;
    logic [3:0]        r_mark;

    // Scan position: the index of the slot now sitting in the head cell.
    logic [IW-1:0]     r_idx, n_idx;

    // Search results of a lookup pass.
    logic              r_hit, n_hit;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic [PRIO_W-1:0] r_best, n_best;
    logic [IW-1:0]     r_pick, n_pick;
    logic              r_found, n_found;

    // Output register.
    logic              r_out_valid;
    logic [3:0]        r_out_idx;
    logic              r_out_found;

    logic  shift;
    logic  last;
    logic  match;
    logic  load_out;
    t_cmd  head_cmd;
    t_slot nexts [SLOTS];

    // The ring: each cell takes from the one after it, the last from the head.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_slot prev;
        t_cmd  cmd;
        if (g == SLOTS - 1) begin : g_tail
            assign prev = nexts[0];
        end else begin : g_mid
            assign prev = nexts[g+1];
        end
        if (g == 0) begin : g_head
            assign cmd = head_cmd;
        end else begin : g_rest
            assign cmd = '0;
        end
        asl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_cmd   (cmd),
            .i_prev  (prev),
            .o_next  (nexts[g])
        );
    end

    assign shift = (r_state == S_FIND) || (r_state == S_WRITE) || (r_state == S_UPDATE);
    assign last  = (r_idx == IW'(SLOTS - 1));
    // During the search pass the head carries no update, so its output is the stored slot.
    assign match = (nexts[0].addr == r_key);

    // Update for the slot leaving the head cell this cycle.
    always_comb begin
        head_cmd      = '0;
        head_cmd.addr = r_key;
        case (r_state)
            S_WRITE: begin
                head_cmd.write = (r_idx == r_pick);
            end
            S_UPDATE: begin
                head_cmd.age  = (r_op == OP_AGE);
                head_cmd.mark = (r_op == OP_MARK) && (MW'(r_mark) == MW'(r_idx));
            end
            default: begin
                head_cmd = head_cmd;
            end
        endcase
    end

    assign load_out = (r_state == S_RESULT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_best    = r_best;
        n_pick    = r_pick;
        n_found   = r_found;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_best  = PRIO_MAX;
                    n_pick  = '0;
                    n_found = 1'b0;
                    if (i_req.operation == OP_LOOKUP) begin
                        n_state = S_FIND;
                    end else if (i_req.operation == OP_AGE || i_req.operation == OP_MARK) begin
                        n_state = S_UPDATE;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_FIND: begin
                n_idx = last ? '0 : r_idx + 1'b1;
                if (!r_hit && match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                // First slot with the strictly lowest priority below the maximum.
                if (nexts[0].prio < r_best) begin
                    n_best = nexts[0].prio;
                    n_pick = r_idx;
                end
                if (last) begin
                    if (n_hit) begin
                        n_pick  = n_hit_idx;
                        n_found = 1'b1;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                n_idx = last ? '0 : r_idx + 1'b1;
                if (last) begin
                    n_state = S_RESULT;
                end
            end
            S_UPDATE: begin
                n_idx = last ? '0 : r_idx + 1'b1;
                if (last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hit   <= n_hit;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx <= n_hit_idx;
        r_best    <= n_best;
        r_pick    <= n_pick;
        r_found   <= n_found;
        if (i_req.valid && i_req.ready) begin
            r_op   <= i_req.operation;
            r_key  <= i_req.address;
            r_mark <= i_req.mark_index;
        end
        if (load_out) begin
            r_out_idx   <= 4'(r_pick);
            r_out_found <= r_found;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.slot_index = r_out_idx;
    assign o_rsp.was_found  = r_out_found;

    // A response appears only from the result-loading state.
    a_rsp_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == S_RESULT))
        else $error("response raised outside the result state");

    // Every pass ends with the ring back in its home position.
    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_idx == '0)
        else $error("scan index not at home while idle");

    // An accepted request closes the request side until it is finished.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in work");

    // The write pass only follows a search that found no match.
    a_write_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> !r_hit && r_op == OP_LOOKUP)
        else $error("write pass after a hit");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the aging slot table: predicted responses versus the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asl_pkg::*;

    localparam int SLOTS = 16;

    // Operation code 3 has no meaning; the block must answer it with zeros.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles without any accepted request or response before the run is declared hung.
    // A correct run stays far below this: a sender gap, a lookup that misses and
    // receiver stalls, which only rarely follow one another.
    localparam int HANG_LIMIT = 2000;

    // Quiet cycles after the last response, enough for a full two-pass lookup and more.
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

    typedef struct packed {
        logic [3:0] slot_index;
        logic       was_found;
    } t_slot_result;

    logic i_clk;
    logic i_rst_n;

    asl_req_if req_ch ();
    asl_rsp_if rsp_ch ();

    aging_slot_table #(
        .SLOTS (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Own copy of the slot table, updated as each request is accepted.
    logic [15:0] table_addr [SLOTS];
    logic [5:0]  table_prio [SLOTS];
    logic        table_flag [SLOTS];

    // Results still owed by the block, oldest first.
    t_slot_result pending_results [$];

    int error_count;
    int quiet_cycles;

    // Percent chance that a sender gap or a receiver stall starts at a given point.
    int gap_pct;
    int stall_pct;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Work out what the block must answer for one request and update the table copy.
    task automatic predict_request(input logic [1:0] op, input logic [15:0] addr,
                                   input logic [3:0] mark, output t_slot_result res);
        logic [5:0] lowest;
        int         victim;
        bit         hit;
        res = '0;
        hit = 1'b0;
        case (op)
            OP_LOOKUP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && table_addr[i] == addr) begin
                        hit = 1'b1;
                        res.slot_index = 4'(i);
                    end
                end
                if (hit) begin
                    res.was_found = 1'b1;
                end else begin
                    // The first slot with the lowest priority under the ceiling is taken;
                    // when every slot sits at the ceiling, slot 0 is reused.
                    lowest = PRIO_MAX;
                    victim = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (table_prio[i] < lowest) begin
                            lowest = table_prio[i];
                            victim = i;
                        end
                    end
                    // The used flag survives commissioning.
                    table_addr[victim] = addr;
                    table_prio[victim] = PRIO_NEW;
                    res.slot_index = 4'(victim);
                end
            end
            OP_AGE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (table_flag[i]) begin
                        table_flag[i] = 1'b0;
                        if (table_prio[i] < PRIO_MAX) begin
                            table_prio[i] = table_prio[i] + 6'd1;
                        end
                    end else if (table_prio[i] != 6'd0) begin
                        table_prio[i] = table_prio[i] - 6'd1;
                    end
                end
            end
            OP_MARK: begin
                if (int'(mark) < SLOTS) begin
                    table_flag[mark] = 1'b1;
                end
            end
            default: begin
                // Unused code: nothing changes and the answer is all zero.
            end
        endcase
    endtask

    // Present one request, hold it until accepted, then record its expected result.
    // Called and returning at a falling edge.
    task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                                input logic [3:0] mark);
        t_slot_result res;
        int           gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 16);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.operation  = op;
        req_ch.address    = addr;
        req_ch.mark_index = mark;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        predict_request(op, addr, mark, res);
        pending_results.push_back(res);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    // Receiver side: ready drops in bursts.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Every accepted response is compared with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_slot_result exp_res;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding: slot_index %0d was_found %0d",
                       rsp_ch.slot_index, rsp_ch.was_found);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (rsp_ch.slot_index !== exp_res.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           exp_res.slot_index, rsp_ch.slot_index);
                    error_count++;
                end
                if (rsp_ch.was_found !== exp_res.was_found) begin
                    $error("was_found: expected %0d, got %0d",
                           exp_res.was_found, rsp_ch.was_found);
                    error_count++;
                end
            end
        end
    end

    // Hang detection: any handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("aging_slot_table: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hits on the reset contents, the first commissions, marks, ticks, the
    // unused code and a commission onto a slot whose flag is already set.
    task automatic test_directed();
        send_request(OP_LOOKUP, 16'h0000, 4'h0);   // every slot holds 0 after reset
        send_request(OP_LOOKUP, 16'hFFFF, 4'h0);   // miss, all priorities equal: slot 0
        send_request(OP_LOOKUP, 16'hFFFF, 4'hF);
        send_request(OP_LOOKUP, 16'h0000, 4'h0);   // now first found in slot 1
        send_request(OP_LOOKUP, 16'h8000, 4'h0);
        send_request(OP_LOOKUP, 16'h0001, 4'h0);
        send_request(OP_MARK,   16'hFFFF, 4'h0);
        send_request(OP_MARK,   16'h0000, 4'hF);
        send_request(OP_UNUSED, 16'hFFFF, 4'hF);
        send_request(OP_UNUSED, 16'h0000, 4'h0);
        send_request(OP_AGE,    16'h5A5A, 4'hA);
        send_request(OP_AGE,    16'hA5A5, 4'h5);
        // Mark a slot that still holds 0 at the lowest priority, then commission
        // over it; the next tick shows whether the flag survived.
        send_request(OP_MARK,   16'h0000, 4'h4);
        send_request(OP_LOOKUP, 16'h1234, 4'h0);
        send_request(OP_LOOKUP, 16'h4321, 4'h0);
        send_request(OP_AGE,    16'h0000, 4'h0);
        send_request(OP_LOOKUP, 16'h7FFF, 4'h0);
        send_request(OP_LOOKUP, 16'h1234, 4'h0);
        send_request(OP_LOOKUP, 16'h0000, 4'h0);
        send_request(OP_MARK,   16'h0000, 4'h8);
    endtask

    // Commission fresh addresses so that every slot starts near the middle, then
    // run mark-then-tick rounds until every slot sits at the priority ceiling, and
    // check that misses fall back on slot 0 and that the ceiling holds.
    task automatic test_saturation();
        bit below;
        for (int s = 0; s < SLOTS; s++) begin
            send_request(OP_LOOKUP, 16'hC000 | 16'(s), 4'($urandom));
        end
        below = 1'b1;
        while (below) begin
            for (int s = 0; s < SLOTS; s++) begin
                send_request(OP_MARK, 16'($urandom), 4'(s));
            end
            send_request(OP_AGE, 16'($urandom), 4'($urandom));
            below = 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                if (table_prio[s] < PRIO_MAX) begin
                    below = 1'b1;
                end
            end
        end
        send_request(OP_LOOKUP, table_addr[5], 4'($urandom));
        send_request(OP_LOOKUP, 16'($urandom), 4'($urandom));
        send_request(OP_LOOKUP, 16'($urandom), 4'($urandom));
        send_request(OP_LOOKUP, table_addr[SLOTS-1], 4'($urandom));
    endtask

    // Mixed traffic over a pool of addresses a little larger than the table, so
    // that hits, misses and evictions all occur, with marks and ticks keeping the
    // priorities spread. Idling changes every few dozen requests.
    task automatic test_random_mix(input int count);
        logic [15:0] addr_pool [24];
        logic [15:0] addr;
        int          pick;
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++) begin
            addr_pool[i] = 16'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7) begin
                addr = addr_pool[$urandom_range(0, 23)];
            end else begin
                addr = 16'($urandom);
            end
            if (pick < 50) begin
                send_request(OP_LOOKUP, addr, 4'($urandom));
            end else if (pick < 75) begin
                send_request(OP_MARK, addr, 4'($urandom));
            end else if (pick < 95) begin
                send_request(OP_AGE, addr, 4'($urandom));
            end else begin
                send_request(OP_UNUSED, addr, 4'($urandom));
            end
        end
    endtask

    // Closing stretch with no idling on either side: requests follow each other
    // as fast as the block takes them and every response is taken at once.
    task automatic test_back_to_back(input int count);
        gap_pct   = 0;
        stall_pct = 0;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: send_request(OP_LOOKUP, 16'($urandom_range(0, 31)), 4'($urandom));
                4, 5:       send_request(OP_MARK, 16'($urandom), 4'($urandom));
                6:          send_request(OP_AGE, 16'($urandom), 4'($urandom));
                default:    send_request(OP_UNUSED, 16'($urandom), 4'($urandom));
            endcase
        end
    endtask

    initial begin
        error_count       = 0;
        quiet_cycles      = 0;
        gap_pct           = 20;
        stall_pct         = 20;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_LOOKUP;
        req_ch.address    = '0;
        req_ch.mark_index = '0;
        for (int i = 0; i < SLOTS; i++) begin
            table_addr[i] = '0;
            table_prio[i] = '0;
            table_flag[i] = 1'b0;
        end

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_saturation();
        test_random_mix(100);
        test_back_to_back(20);

        // Let every outstanding response arrive, then watch for strays.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("aging_slot_table: match");
        end else begin
            $display("aging_slot_table: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/asl_pkg.sv
src/asl_if.sv
src/asl_cell.sv
src/aging_slot_table.sv
sim/tb_top.sv
